// ===== sv/bse_pkg.sv =====
// Shared constants and types for the bounded stack engine.
package bse_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VALUE_W = 32;
    localparam int POS_W   = 8;
    localparam int KIND_W  = 3;
    localparam int STAT_W  = 3;
    localparam int TDATA_W = ((VALUE_W + POS_W + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH   = 3'd0,
        KIND_POP    = 3'd1,
        KIND_UPDATE = 3'd2,
        KIND_SEARCH = 3'd3,
        KIND_VIEW   = 3'd4
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_EMPTY    = 3'd2,
        STAT_BADPOS   = 3'd3,
        STAT_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SINGLE,
        FSM_SCAN,
        FSM_VIEW
    } fsm_t;

endpackage

// ===== sv/bounded_stack_engine.sv =====
// Top level of the bounded stack engine: request decode, sequencer and result register.
// Push, pop and update each give a single result, through the single-result state and the result register.
// Search compares one stored entry per cycle from the top.
// View delivers one entry per cycle from the top while the output is free, count results, the last one marked.
// Each request is worked alone; the stack memory's single read port sets the scan rate.
// Reset (aresetn low, synchronous) empties the stack; the entry memory is not cleared.
module bounded_stack_engine (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bse_pkg::TDATA_W-1:0]  s_tdata,  // value[31:0], position[39:32]
    input  logic [bse_pkg::KIND_W-1:0]   s_tuser,  // kind[2:0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bse_pkg::TDATA_W-1:0]  m_tdata,  // data[31:0], found_position[39:32]
    output logic [bse_pkg::STAT_W-1:0]   m_tuser,  // status[2:0]
    output logic                         m_tlast
);
    import bse_pkg::*;

    fsm_t                     state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         pos_reg, pos_next;
    logic [KIND_W-1:0]        kind_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [POS_W-1:0]         posin_reg;

    logic                     m_tvalid_reg, m_tvalid_next;
    logic [STAT_W-1:0]        status_reg;
    logic [VALUE_W-1:0]       data_reg;
    logic [POS_W-1:0]         fpos_reg;
    logic                     last_reg;

    logic                     accept, out_free, emit;
    logic [STAT_W-1:0]        e_status;
    logic [VALUE_W-1:0]       e_data;
    logic [POS_W-1:0]         e_fpos;
    logic                     e_last;

    logic                     wr_en, rd_en;
    logic [IDX_W-1:0]         wr_addr, rd_addr;
    logic [VALUE_W-1:0]       wr_data, rd_data;

    logic                     is_full, is_empty, bad_pos;
    logic [CNT_W-1:0]         top_idx, upd_idx, next_idx;

    bse_ram #(
        .WIDTH  (VALUE_W),
        .DEPTH  (DEPTH),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_tready = (state_reg == FSM_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign bad_pos  = (posin_reg == '0) || (posin_reg > POS_W'(count_reg));
    assign top_idx  = count_reg - CNT_W'(1);
    assign upd_idx  = count_reg - CNT_W'(posin_reg);
    assign next_idx = count_reg - pos_reg - CNT_W'(1);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        emit       = 1'b0;
        e_status   = STAT_OK;
        e_data     = '0;
        e_fpos     = '0;
        e_last     = 1'b1;
        wr_en      = 1'b0;
        wr_addr    = count_reg[IDX_W-1:0];
        wr_data    = value_reg;
        rd_en      = 1'b0;
        rd_addr    = top_idx[IDX_W-1:0];

        unique case (state_reg)
            FSM_IDLE: begin
                if (accept) begin
                    // The top entry is fetched now so that pop, search and view find it ready.
                    rd_en    = 1'b1;
                    pos_next = CNT_W'(1);
                    case (s_tuser)
                        KIND_PUSH, KIND_POP, KIND_UPDATE: state_next = FSM_SINGLE;
                        KIND_SEARCH: state_next = is_empty ? FSM_SINGLE : FSM_SCAN;
                        KIND_VIEW:   state_next = is_empty ? FSM_SINGLE : FSM_VIEW;
                        default:     state_next = FSM_IDLE;
                    endcase
                end
            end
            FSM_SINGLE: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = FSM_IDLE;
                    case (kind_reg)
                        KIND_PUSH: begin
                            if (is_full) begin
                                e_status = STAT_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        KIND_POP: begin
                            if (is_empty) begin
                                e_status = STAT_EMPTY;
                            end else begin
                                e_data     = rd_data;
                                count_next = top_idx;
                            end
                        end
                        KIND_UPDATE: begin
                            if (is_empty) begin
                                e_status = STAT_EMPTY;
                            end else if (bad_pos) begin
                                e_status = STAT_BADPOS;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = upd_idx[IDX_W-1:0];
                            end
                        end
                        default: e_status = STAT_EMPTY;
                    endcase
                end
            end
            FSM_SCAN: begin
                if ($signed(rd_data) == value_reg) begin
                    if (out_free) begin
                        emit       = 1'b1;
                        e_fpos     = POS_W'(pos_reg);
                        state_next = FSM_IDLE;
                    end
                end else if (pos_reg == count_reg) begin
                    if (out_free) begin
                        emit       = 1'b1;
                        e_status   = STAT_NOTFOUND;
                        state_next = FSM_IDLE;
                    end
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = next_idx[IDX_W-1:0];
                    pos_next = pos_reg + CNT_W'(1);
                end
            end
            FSM_VIEW: begin
                // The read data holds until the next read, so a stalled output just waits.
                if (out_free) begin
                    emit   = 1'b1;
                    e_data = rd_data;
                    e_last = (pos_reg == count_reg);
                    if (pos_reg == count_reg) begin
                        state_next = FSM_IDLE;
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = next_idx[IDX_W-1:0];
                        pos_next = pos_reg + CNT_W'(1);
                    end
                end
            end
            default: state_next = FSM_IDLE;
        endcase

        if (emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FSM_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        if (accept) begin
            kind_reg  <= s_tuser;
            value_reg <= $signed(s_tdata[VALUE_W-1:0]);
            posin_reg <= s_tdata[VALUE_W+POS_W-1:VALUE_W];
        end
        if (emit) begin
            status_reg <= e_status;
            data_reg   <= e_data;
            fpos_reg   <= e_fpos;
            last_reg   <= e_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = TDATA_W'({fpos_reg, data_reg});

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("stack count exceeds depth");

    a_count_only_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !emit |=> $stable(count_reg))
        else $error("stack count changed without a result");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && kind_reg == KIND_PUSH && e_status == STAT_OK)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("successful push did not grow the stack");

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_en && rd_en && wr_addr == rd_addr))
        else $error("read and write of the same entry in one cycle");

    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser <= KIND_VIEW) |=> state_reg != FSM_IDLE)
        else $error("valid request accepted but sequencer stayed idle");
`endif

endmodule

// ===== sv/bse_ram.sv =====
// Single-port-write, single-port-read RAM with a registered read output.
module bse_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
